// ===== rtl/rgbe_rle_pkg.sv =====
package rgbe_rle_pkg;

	localparam int MAX_LINE_WIDTH_DEF = 32767;
	localparam int LINE_W             = 15;

	localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 15'd1024;
	localparam logic [LINE_W-1:0] RLE_MIN_WIDTH    = 15'd8;

	localparam logic [7:0] HEAD_MARK  = 8'd2;
	localparam logic [7:0] RUN_BASE   = 8'd128;
	localparam logic [23:0] REPEAT_MARK = 24'h010101;

	localparam logic [2:0] PLANE_EXP   = 3'd3;
	localparam logic [2:0] PLANE_PIXEL = 3'd4;

	localparam logic [1:0] SHIFT_MAX_STEP = 2'd3;

	typedef enum logic [6:0] {
		PH_LINE = 7'b0000001,
		PH_OLD  = 7'b0000010,
		PH_HEAD = 7'b0000100,
		PH_CODE = 7'b0001000,
		PH_RUN  = 7'b0010000,
		PH_LIT  = 7'b0100000,
		PH_SKIP = 7'b1000000
	} phase_t;

endpackage

// ===== rtl/rgbe_scanline_rle_decoder.sv =====
// RGBE scanline run-length decoder
// in channel: in_valid / in_stall carry data_byte, one encoded byte per transfer
// out channel: out_valid / out_stall carry one fill descriptor per transfer
//   (plane, first_pixel, pixel_count, four bytes, line_done, overrun)
// a byte either updates the decode state only or produces exactly one descriptor
// cfg_we with cfg_wdata writes the line width; write it only while the block is idle
// latency: a byte transferred at edge n gives its descriptor on the outputs after
//   edge n+1 (held in the input register, decoded into the result register)
// throughput: one byte per cycle, set by the single decode step between the
//   input register and the result register
// reset (arst_n low): line width 1024, decoder at line start, previous pixel zero,
//   input and result registers empty
// when out_stall holds a waiting result, the input register still takes one byte;
//   after that in_stall rises until the result transfers
module rgbe_scanline_rle_decoder #(
	parameter int MAX_LINE_WIDTH = rgbe_rle_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rgbe_rle_pkg::LINE_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     plane,
	output logic [rgbe_rle_pkg::LINE_W-1:0] first_pixel,
	output logic [rgbe_rle_pkg::LINE_W-1:0] pixel_count,
	output logic [7:0]                     byte_red,
	output logic [7:0]                     byte_green,
	output logic [7:0]                     byte_blue,
	output logic [7:0]                     byte_exponent,
	output logic                           line_done,
	output logic                           overrun
);
	import rgbe_rle_pkg::*;

	logic [LINE_W-1:0] line_width_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;

	phase_t            phase_q, phase_d;
	logic [23:0]       gather_q, gather_d;
	logic [1:0]        gcount_q, gcount_d;
	logic [31:0]       prev_q, prev_d;
	logic [1:0]        shift_q, shift_d;
	logic [1:0]        cplane_q, cplane_d;
	logic [LINE_W-1:0] pos_q, pos_d;
	logic [7:0]        lit_q, lit_d;

	logic              out_valid_q;
	logic [2:0]        plane_q;
	logic [LINE_W-1:0] first_q, count_q;
	logic [7:0]        red_q, green_q, blue_q, exp_q;
	logic              done_q, over_q;

	logic [LINE_W-1:0] width_eff;
	logic [LINE_W-1:0] rem;
	logic [LINE_W-1:0] avail;
	logic [31:0]       req;
	logic [31:0]       rep_req;
	logic              fill_end;
	logic [LINE_W-1:0] fill_cnt;
	logic              fill_over;
	logic              emit;
	logic              whole;
	logic [31:0]       fill_px;
	logic [31:0]       old_px;
	logic [31:0]       head_px;
	logic [7:0]        lit_dec;
	logic              head_old;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign width_eff = (line_width_q == '0) ? LINE_W'(1) : line_width_q;
	assign rem       = (pos_q < width_eff) ? (width_eff - pos_q) : '0;
	assign avail     = (rem == '0) ? LINE_W'(1) : rem;

	assign old_px  = {byte_s1, gather_q};
	assign head_px = {byte_s1, gather_q[23:16], gather_q[15:8], HEAD_MARK};
	assign lit_dec = (lit_q != '0) ? (lit_q - 8'd1) : '0;
	assign head_old = (gather_q[15:8] != HEAD_MARK) || gather_q[23];

	always_comb begin
		case (shift_q)
			2'd0:    rep_req = {24'd0, byte_s1};
			2'd1:    rep_req = {16'd0, byte_s1, 8'd0};
			2'd2:    rep_req = {8'd0, byte_s1, 16'd0};
			default: rep_req = {byte_s1, 24'd0};
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_RUN:  req = {24'd0, lit_q};
			PH_OLD:  req = (gather_q == REPEAT_MARK) ? rep_req : 32'd1;
			default: req = 32'd1;
		endcase
	end

	assign fill_end  = (rem == '0) || (req >= {17'd0, rem});
	assign fill_cnt  = (req < {17'd0, avail}) ? req[LINE_W-1:0] : avail;
	assign fill_over = req > {17'd0, rem};

	always_comb begin
		phase_d  = phase_q;
		gather_d = gather_q;
		gcount_d = gcount_q;
		prev_d   = prev_q;
		shift_d  = shift_q;
		cplane_d = cplane_q;
		pos_d    = pos_q;
		lit_d    = lit_q;
		emit     = 1'b0;
		whole    = 1'b0;
		fill_px  = prev_q;
		case (phase_q)
			PH_OLD: begin
				if (gcount_q != SHIFT_MAX_STEP) begin
					case (gcount_q)
						2'd0:    gather_d[7:0]   = gather_q[7:0] | byte_s1;
						2'd1:    gather_d[15:8]  = gather_q[15:8] | byte_s1;
						default: gather_d[23:16] = gather_q[23:16] | byte_s1;
					endcase
					gcount_d = gcount_q + 2'd1;
				end else begin
					gcount_d = '0;
					gather_d = '0;
					whole    = 1'b1;
					if (gather_q == REPEAT_MARK) begin
						fill_px = prev_q;
						emit    = (byte_s1 != '0);
						if (shift_q != SHIFT_MAX_STEP)
							shift_d = shift_q + 2'd1;
					end else begin
						fill_px = old_px;
						emit    = 1'b1;
						prev_d  = old_px;
						shift_d = '0;
					end
					if (emit && fill_end)
						phase_d = PH_LINE;
				end
			end
			PH_HEAD: begin
				if (gcount_q != 2'd2) begin
					if (gcount_q == 2'd0)
						gather_d[15:8] = gather_q[15:8] | byte_s1;
					else
						gather_d[23:16] = gather_q[23:16] | byte_s1;
					gcount_d = gcount_q + 2'd1;
				end else begin
					gcount_d = '0;
					gather_d = '0;
					if (head_old) begin
						prev_d  = head_px;
						shift_d = '0;
						emit    = 1'b1;
						whole   = 1'b1;
						fill_px = head_px;
						phase_d = fill_end ? PH_LINE : PH_OLD;
					end else begin
						cplane_d = '0;
						pos_d    = '0;
						phase_d  = PH_CODE;
					end
				end
			end
			PH_CODE: begin
				if (byte_s1 > RUN_BASE) begin
					lit_d   = {1'b0, byte_s1[6:0]};
					phase_d = PH_RUN;
				end else if (byte_s1 != '0) begin
					lit_d   = byte_s1;
					phase_d = PH_LIT;
				end
			end
			PH_RUN: begin
				emit  = 1'b1;
				lit_d = '0;
				if (fill_end) begin
					prev_d[{cplane_q, 3'b000} +: 8] = byte_s1;
					if (cplane_q == 2'd3) begin
						phase_d  = PH_LINE;
						cplane_d = '0;
					end else begin
						cplane_d = cplane_q + 2'd1;
						phase_d  = PH_CODE;
					end
				end else begin
					phase_d = PH_CODE;
				end
			end
			PH_LIT: begin
				emit  = 1'b1;
				lit_d = lit_dec;
				if (fill_end) begin
					prev_d[{cplane_q, 3'b000} +: 8] = byte_s1;
					if (lit_dec != '0) begin
						phase_d = PH_SKIP;
					end else if (cplane_q == 2'd3) begin
						phase_d  = PH_LINE;
						cplane_d = '0;
					end else begin
						cplane_d = cplane_q + 2'd1;
						phase_d  = PH_CODE;
					end
				end else if (lit_dec == '0) begin
					phase_d = PH_CODE;
				end
			end
			PH_SKIP: begin
				if (lit_q > 8'd1) begin
					lit_d = lit_q - 8'd1;
				end else begin
					pos_d = '0;
					lit_d = '0;
					if (cplane_q == 2'd3) begin
						phase_d  = PH_LINE;
						cplane_d = '0;
					end else begin
						cplane_d = cplane_q + 2'd1;
						phase_d  = PH_CODE;
					end
				end
			end
			default: begin
				pos_d    = '0;
				shift_d  = '0;
				cplane_d = '0;
				lit_d    = '0;
				if (width_eff >= RLE_MIN_WIDTH && width_eff <= LINE_W'(MAX_LINE_WIDTH) &&
				    byte_s1 == HEAD_MARK) begin
					gather_d = '0;
					gcount_d = '0;
					phase_d  = PH_HEAD;
				end else begin
					gather_d = {16'd0, byte_s1};
					gcount_d = 2'd1;
					phase_d  = PH_OLD;
				end
			end
		endcase
		if (emit)
			pos_d = fill_end ? '0 : (pos_q + req[LINE_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE;
			gather_q <= '0;
			gcount_q <= '0;
			prev_q   <= '0;
			shift_q  <= '0;
			cplane_q <= '0;
			pos_q    <= '0;
			lit_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			gather_q <= gather_d;
			gcount_q <= gcount_d;
			prev_q   <= prev_d;
			shift_q  <= shift_d;
			cplane_q <= cplane_d;
			pos_q    <= pos_d;
			lit_q    <= lit_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			plane_q <= whole ? PLANE_PIXEL : {1'b0, cplane_q};
			first_q <= pos_q;
			count_q <= fill_cnt;
			if (whole) begin
				red_q   <= fill_px[7:0];
				green_q <= fill_px[15:8];
				blue_q  <= fill_px[23:16];
				exp_q   <= fill_px[31:24];
			end else begin
				red_q   <= byte_s1;
				green_q <= '0;
				blue_q  <= '0;
				exp_q   <= '0;
			end
			done_q <= fill_end && (whole || cplane_q == 2'd3);
			over_q <= fill_over || (phase_q == PH_LIT && fill_end && lit_dec != '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign plane         = plane_q;
	assign first_pixel   = first_q;
	assign pixel_count   = count_q;
	assign byte_red      = red_q;
	assign byte_green    = green_q;
	assign byte_blue     = blue_q;
	assign byte_exponent = exp_q;
	assign line_done     = done_q;
	assign overrun       = over_q;

`ifndef SYNTHESIS
	a_end_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && fill_end) |=> (pos_q == '0))
		else $error("fill reaching line end did not clear the pixel position");

	a_gcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_OLD) |-> (gcount_q != 2'd3))
		else $error("byte gather count out of range outside old format");

	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (lit_q != '0))
		else $error("skipping literal bytes with none left");

	a_done_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (plane_q == PLANE_EXP || plane_q == PLANE_PIXEL))
		else $error("line done flagged on a colour plane fill");
`endif

endmodule
